// File: src/stq_pkg.sv
// Shared types, constants and codes for the sorted timer queue.
`default_nettype none

package stq_pkg;

  localparam int unsigned MAX_TIMERS_DEF = 16;
  localparam int unsigned RESULT_CAP     = 16;
  localparam int unsigned RES_CNT_W      = $clog2(RESULT_CAP + 1);

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 24;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned REM_W   = 25;
  localparam int unsigned STAT_W  = 2;

  localparam logic [DELAY_W-1:0] REMAIN_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD     = 3'd0,
    MODE_CANCEL  = 3'd1,
    MODE_EXPIRE  = 3'd2,
    MODE_QUERY   = 3'd3,
    MODE_CLR_ALL = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_BAD_ID  = 2'd2,
    STS_NOT_DUE = 2'd3
  } status_e;

  typedef struct packed {
    logic [TIME_W-1:0] deadline;
    logic [ID_W-1:0]   ident;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_READ,
    OP_SHIFT_RD,
    OP_CLOSE_RD,
    OP_FIND_EV,
    OP_SHIFT_WR,
    OP_INSERT,
    OP_SRCH_EV,
    OP_CLOSE_WR,
    OP_DROP,
    OP_EXP_EV,
    OP_EXP_END,
    OP_QUERY,
    OP_CLEAR,
    OP_REPLY
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FIND,
    S_FIND_RD,
    S_SH_RD,
    S_SH_WR,
    S_INSERT,
    S_SRCH,
    S_SRCH_RD,
    S_CL_RD,
    S_CL_WR,
    S_DROP,
    S_EXP,
    S_EXP_RD,
    S_EXP_END,
    S_QUERY
  } state_e;

  typedef struct packed {
    op_e     op;
    status_e rsts;
  } stq_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  cnt_zero;
    logic  cnt_full;
    logic  target_zero;
    logic  find_hit;
    logic  id_hit;
    logic  idx_last;
    logic  sh_more;
    logic  cl_more;
  } stq_stat_t;

endpackage

`default_nettype wire

// File: src/stq_ctrl.sv
// Request sequencer of the sorted timer queue: walks the table via datapath ops.
`default_nettype none

module stq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire stq_pkg::stq_stat_t stat_i,
  output stq_pkg::stq_cmd_t      cmd_o,
  output logic                   busy_o
);
  import stq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.mode)
          MODE_ADD: begin
            if (stat_i.cnt_full || stat_i.cnt_zero) state_d = S_IDLE;
            else state_d = S_FIND;
          end
          MODE_CANCEL: begin
            if (stat_i.target_zero || stat_i.cnt_zero) state_d = S_IDLE;
            else state_d = S_SRCH;
          end
          MODE_EXPIRE: begin
            if (stat_i.cnt_zero) state_d = S_IDLE;
            else state_d = S_EXP;
          end
          MODE_QUERY: state_d = S_QUERY;
          default:    state_d = S_IDLE;
        endcase
      end
      S_FIND: begin
        if (stat_i.find_hit) state_d = S_SH_RD;
        else if (stat_i.idx_last) state_d = S_INSERT;
        else state_d = S_FIND_RD;
      end
      S_FIND_RD: state_d = S_FIND;
      S_SH_RD:   state_d = S_SH_WR;
      S_SH_WR: begin
        if (stat_i.sh_more) state_d = S_SH_RD;
        else state_d = S_INSERT;
      end
      S_INSERT: state_d = S_IDLE;
      S_SRCH: begin
        if (stat_i.id_hit && stat_i.idx_last) state_d = S_DROP;
        else if (stat_i.id_hit) state_d = S_CL_RD;
        else if (stat_i.idx_last) state_d = S_IDLE;
        else state_d = S_SRCH_RD;
      end
      S_SRCH_RD: state_d = S_SRCH;
      S_CL_RD:   state_d = S_CL_WR;
      S_CL_WR: begin
        if (stat_i.cl_more) state_d = S_CL_RD;
        else state_d = S_DROP;
      end
      S_DROP: state_d = S_IDLE;
      S_EXP: begin
        if (stat_i.idx_last) state_d = S_EXP_END;
        else state_d = S_EXP_RD;
      end
      S_EXP_RD:  state_d = S_EXP;
      S_EXP_END: state_d = S_IDLE;
      S_QUERY:   state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o.op   = OP_IDLE;
    cmd_o.rsts = STS_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) cmd_o.op = OP_LOAD;
      end
      S_DECODE: begin
        case (stat_i.mode)
          MODE_ADD: begin
            if (stat_i.cnt_full) begin
              cmd_o.op   = OP_REPLY;
              cmd_o.rsts = STS_FULL;
            end else if (stat_i.cnt_zero) begin
              cmd_o.op = OP_INSERT;
            end else begin
              cmd_o.op = OP_READ;
            end
          end
          MODE_CANCEL: begin
            if (stat_i.target_zero || stat_i.cnt_zero) begin
              cmd_o.op   = OP_REPLY;
              cmd_o.rsts = STS_BAD_ID;
            end else begin
              cmd_o.op = OP_READ;
            end
          end
          MODE_EXPIRE: begin
            if (stat_i.cnt_zero) begin
              cmd_o.op   = OP_REPLY;
              cmd_o.rsts = STS_NOT_DUE;
            end else begin
              cmd_o.op = OP_READ;
            end
          end
          MODE_QUERY:   cmd_o.op = OP_READ;
          MODE_CLR_ALL: cmd_o.op = OP_CLEAR;
          default: begin
            cmd_o.op   = OP_REPLY;
            cmd_o.rsts = STS_BAD_ID;
          end
        endcase
      end
      S_FIND:    cmd_o.op = OP_FIND_EV;
      S_FIND_RD: cmd_o.op = OP_READ;
      S_SH_RD:   cmd_o.op = OP_SHIFT_RD;
      S_SH_WR:   cmd_o.op = OP_SHIFT_WR;
      S_INSERT:  cmd_o.op = OP_INSERT;
      S_SRCH:    cmd_o.op = OP_SRCH_EV;
      S_SRCH_RD: cmd_o.op = OP_READ;
      S_CL_RD:   cmd_o.op = OP_CLOSE_RD;
      S_CL_WR:   cmd_o.op = OP_CLOSE_WR;
      S_DROP:    cmd_o.op = OP_DROP;
      S_EXP:     cmd_o.op = OP_EXP_EV;
      S_EXP_RD:  cmd_o.op = OP_READ;
      S_EXP_END: cmd_o.op = OP_EXP_END;
      S_QUERY:   cmd_o.op = OP_QUERY;
      default:   cmd_o.op = OP_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: src/stq_datapath.sv
// Timer table memory, walk counters and result registers of the sorted timer queue.
`default_nettype none

module stq_datapath #(
  parameter int unsigned MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire stq_pkg::stq_cmd_t            cmd_i,
  output stq_pkg::stq_stat_t                stat_o,
  input  wire logic [stq_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [stq_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic [stq_pkg::DELAY_W-1:0]  delay_ms_i,
  input  wire logic [stq_pkg::TAG_W-1:0]    callback_tag_i,
  input  wire logic [stq_pkg::ID_W-1:0]     target_id_i,
  output logic                              result_valid_o,
  output logic [stq_pkg::STAT_W-1:0]        status_o,
  output logic [stq_pkg::ID_W-1:0]          timer_ident_o,
  output logic [stq_pkg::TAG_W-1:0]         expired_tag_o,
  output logic signed [stq_pkg::REM_W-1:0]  remaining_ms_o,
  output logic                              last_o
);
  import stq_pkg::*;

  localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TIMERS);
  localparam logic [RES_CNT_W-1:0] RES_CAP = RES_CNT_W'(RESULT_CAP);

  // latched request
  logic [MODE_W-1:0]  mode_q, mode_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  dl_q, dl_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [ID_W-1:0]    target_q, target_d;

  // table control
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ID_W-1:0]      id_ctr_q, id_ctr_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     keep_q, keep_d;
  logic [RES_CNT_W-1:0] nres_q, nres_d;
  logic                 pend_v_q, pend_v_d;
  logic [ID_W-1:0]      pend_id_q, pend_id_d;
  logic [TAG_W-1:0]     pend_tag_q, pend_tag_d;

  // result register
  logic               res_valid_q, res_valid_d;
  status_e            res_status_q, res_status_d;
  logic [ID_W-1:0]    res_ident_q, res_ident_d;
  logic [TAG_W-1:0]   res_tag_q, res_tag_d;
  logic [REM_W-1:0]   res_remain_q, res_remain_d;
  logic               res_last_q, res_last_d;

  // table memory
  entry_t             mem_q [MAX_TIMERS];
  entry_t             rd_q;
  entry_t             wr_data;
  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;

  logic [CNT_W:0]     idx_p1, idx_p2, pos_p1;
  logic [CNT_W-1:0]   idx_m1;
  logic [TIME_W-1:0]  diff_dl, diff_now;
  logic               find_hit, id_hit, due, exp_take, idx_last;
  logic [ID_W-1:0]    new_id;

  assign idx_p1   = {1'b0, idx_q} + 1'b1;
  assign idx_p2   = {1'b0, idx_q} + 2'd2;
  assign pos_p1   = {1'b0, pos_q} + 1'b1;
  assign idx_m1   = idx_q - 1'b1;
  assign idx_last = (idx_p1 == {1'b0, count_q});

  // wrap-safe compares against the entry just read
  assign diff_dl  = dl_q - rd_q.deadline;
  assign diff_now = rd_q.deadline - now_q;
  assign find_hit = diff_dl[TIME_W-1];
  assign due      = (diff_now == '0) || diff_now[TIME_W-1];
  assign exp_take = due && (nres_q < RES_CAP);
  assign id_hit   = (rd_q.ident == target_q);
  assign new_id   = id_ctr_q + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    now_d      = now_q;
    dl_d       = dl_q;
    tag_d      = tag_q;
    target_d   = target_q;
    count_d    = count_q;
    id_ctr_d   = id_ctr_q;
    idx_d      = idx_q;
    pos_d      = pos_q;
    keep_d     = keep_q;
    nres_d     = nres_q;
    pend_v_d   = pend_v_q;
    pend_id_d  = pend_id_q;
    pend_tag_d = pend_tag_q;

    wr_en   = 1'b0;
    wr_addr = idx_q[IDX_W-1:0];
    wr_data = rd_q;
    rd_en   = 1'b0;
    rd_addr = idx_q[IDX_W-1:0];

    res_valid_d  = 1'b0;
    res_status_d = STS_OK;
    res_ident_d  = '0;
    res_tag_d    = '0;
    res_remain_d = '0;
    res_last_d   = 1'b1;

    case (cmd_i.op)
      OP_LOAD: begin
        mode_d   = mode_i;
        now_d    = now_ms_i;
        dl_d     = now_ms_i + TIME_W'(delay_ms_i);
        tag_d    = callback_tag_i;
        target_d = target_id_i;
        idx_d    = '0;
        pos_d    = count_q;
        keep_d   = '0;
        nres_d   = '0;
        pend_v_d = 1'b0;
      end
      OP_READ: begin
        rd_en = 1'b1;
      end
      OP_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[IDX_W-1:0];
      end
      OP_CLOSE_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_p1[IDX_W-1:0];
      end
      OP_FIND_EV: begin
        if (find_hit) begin
          pos_d = idx_q;
          idx_d = count_q;
        end else if (idx_last) begin
          idx_d = count_q;
        end else begin
          idx_d = idx_p1[CNT_W-1:0];
        end
      end
      OP_SHIFT_WR: begin
        wr_en = 1'b1;
        idx_d = idx_m1;
      end
      OP_INSERT: begin
        wr_en       = 1'b1;
        wr_addr     = pos_q[IDX_W-1:0];
        wr_data     = '{deadline: dl_q, ident: new_id, tag: tag_q};
        id_ctr_d    = new_id;
        count_d     = count_q + 1'b1;
        res_valid_d = 1'b1;
        res_ident_d = new_id;
      end
      OP_SRCH_EV: begin
        if (!id_hit) begin
          idx_d = idx_p1[CNT_W-1:0];
          if (idx_last) begin
            res_valid_d  = 1'b1;
            res_status_d = STS_BAD_ID;
          end
        end
      end
      OP_CLOSE_WR: begin
        wr_en = 1'b1;
        idx_d = idx_p1[CNT_W-1:0];
      end
      OP_DROP: begin
        count_d     = count_q - 1'b1;
        res_valid_d = 1'b1;
      end
      OP_EXP_EV: begin
        // a held result goes out once the next due entry shows it was not last
        if (exp_take) begin
          if (pend_v_q) begin
            res_valid_d = 1'b1;
            res_ident_d = pend_id_q;
            res_tag_d   = pend_tag_q;
            res_last_d  = 1'b0;
          end
          pend_v_d   = 1'b1;
          pend_id_d  = rd_q.ident;
          pend_tag_d = rd_q.tag;
          nres_d     = nres_q + 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = keep_q[IDX_W-1:0];
          keep_d  = keep_q + 1'b1;
        end
        idx_d = idx_p1[CNT_W-1:0];
      end
      OP_EXP_END: begin
        count_d     = keep_q;
        res_valid_d = 1'b1;
        if (pend_v_q) begin
          res_ident_d = pend_id_q;
          res_tag_d   = pend_tag_q;
        end else begin
          res_status_d = STS_NOT_DUE;
        end
      end
      OP_QUERY: begin
        res_valid_d = 1'b1;
        if (count_q == '0) begin
          res_remain_d = '1;
        end else if (diff_now[TIME_W-1]) begin
          res_remain_d = '0;
        end else if (|diff_now[TIME_W-1:DELAY_W]) begin
          res_remain_d = {1'b0, REMAIN_MAX};
        end else begin
          res_remain_d = {1'b0, diff_now[DELAY_W-1:0]};
        end
      end
      OP_CLEAR: begin
        count_d     = '0;
        id_ctr_d    = ID_W'(1);
        res_valid_d = 1'b1;
      end
      OP_REPLY: begin
        res_valid_d  = 1'b1;
        res_status_d = cmd_i.rsts;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      id_ctr_q    <= ID_W'(1);
      idx_q       <= '0;
      pos_q       <= '0;
      keep_q      <= '0;
      nres_q      <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      id_ctr_q    <= id_ctr_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      keep_q      <= keep_d;
      nres_q      <= nres_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    now_q        <= now_d;
    dl_q         <= dl_d;
    tag_q        <= tag_d;
    target_q     <= target_d;
    pend_id_q    <= pend_id_d;
    pend_tag_q   <= pend_tag_d;
    res_status_q <= res_status_d;
    res_ident_q  <= res_ident_d;
    res_tag_q    <= res_tag_d;
    res_remain_q <= res_remain_d;
    res_last_q   <= res_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  assign stat_o.mode        = mode_e'(mode_q);
  assign stat_o.cnt_zero    = (count_q == '0);
  assign stat_o.cnt_full    = (count_q >= CNT_MAX);
  assign stat_o.target_zero = (target_q == '0);
  assign stat_o.find_hit    = find_hit;
  assign stat_o.id_hit      = id_hit;
  assign stat_o.idx_last    = idx_last;
  assign stat_o.sh_more     = ({1'b0, idx_q} > pos_p1);
  assign stat_o.cl_more     = (idx_p2 < {1'b0, count_q});

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign timer_ident_o  = res_ident_q;
  assign expired_tag_o  = res_tag_q;
  assign remaining_ms_o = res_remain_q;
  assign last_o         = res_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_MAX)
    else $error("entry count above table size");

  a_res_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= RES_CAP)
    else $error("expire reported more than the cap");

  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_INSERT |=> res_valid_q && res_status_q == STS_OK && res_last_q)
    else $error("insert did not report success");

  a_mid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_last_q |-> res_status_q == STS_OK && pend_v_q)
    else $error("non-final result outside an expire run");

endmodule

`default_nettype wire

// File: src/sorted_timer_queue_unit.sv
// Top level of the sorted timer queue: controller plus table datapath.
//
// Usage: drive mode_i and its operand fields with start_i high; the request
// is taken at a clock edge where start_i is high and busy_o is low. busy_o
// stays high while the request walks the table. Each result appears on the
// result ports for exactly one cycle with result_valid_o high; last_o marks
// the final result of the request. The receiver cannot stall: results must
// be captured when the strobe is high.
// Add, cancel, query, cancel-all and bad modes give one result; expire gives
// one result per due entry (at most 16) or a single "nothing due" result.
// Each table entry is first read from the table memory into a register and
// then compared or moved. Add walks the entries up to its slot, then shifts
// the later ones; cancel walks up to the match, then closes the gap; expire
// walks every entry; query reads only the first entry.
// A new request can be taken in the cycle its predecessor's last result is
// shown. Reset empties the table and sets the id counter to one; table
// contents are not cleared, only the count.
`default_nettype none

module sorted_timer_queue_unit #(
  parameter int unsigned MAX_TIMERS = stq_pkg::MAX_TIMERS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [stq_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [stq_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic [stq_pkg::DELAY_W-1:0]  delay_ms_i,
  input  wire logic [stq_pkg::TAG_W-1:0]    callback_tag_i,
  input  wire logic [stq_pkg::ID_W-1:0]     target_id_i,
  output logic                              result_valid_o,
  output logic [stq_pkg::STAT_W-1:0]        status_o,
  output logic [stq_pkg::ID_W-1:0]          timer_ident_o,
  output logic [stq_pkg::TAG_W-1:0]         expired_tag_o,
  output logic signed [stq_pkg::REM_W-1:0]  remaining_ms_o,
  output logic                              last_o
);
  import stq_pkg::*;

  stq_cmd_t  cmd;
  stq_stat_t stat;

  stq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  stq_datapath #(
    .MAX_TIMERS (MAX_TIMERS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .mode_i         (mode_i),
    .now_ms_i       (now_ms_i),
    .delay_ms_i     (delay_ms_i),
    .callback_tag_i (callback_tag_i),
    .target_id_i    (target_id_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .timer_ident_o  (timer_ident_o),
    .expired_tag_o  (expired_tag_o),
    .remaining_ms_o (remaining_ms_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the sorted timer queue: random and directed requests.
`timescale 1ns / 100ps

module testbench;
  import stq_pkg::*;

  localparam int          TABLE_DEPTH  = MAX_TIMERS_DEF;
  localparam int          RANDOM_ITEMS = 340;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          TAIL_CYCLES  = 100;
  localparam int          MAX_PRINTS   = 40;
  localparam logic [MODE_W-1:0] MODE_RSVD_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_HI = 3'd7;

  typedef struct {
    logic [MODE_W-1:0]  op;
    logic [TIME_W-1:0]  now;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    target;
    int unsigned        gap;
    bit                 drain;
  } timer_req_t;

  typedef struct {
    logic [STAT_W-1:0]       sts;
    logic [ID_W-1:0]         ident;
    logic [TAG_W-1:0]        tag;
    logic signed [REM_W-1:0] remain;
    logic                    last;
  } timer_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start_req = 1'b0;
  logic [MODE_W-1:0]        mode = '0;
  logic [TIME_W-1:0]        now_ms = '0;
  logic [DELAY_W-1:0]       delay_ms = '0;
  logic [TAG_W-1:0]         callback_tag = '0;
  logic [ID_W-1:0]          target_id = '0;
  logic                     busy;
  logic                     res_valid;
  logic [STAT_W-1:0]        status;
  logic [ID_W-1:0]          timer_ident;
  logic [TAG_W-1:0]         expired_tag;
  logic signed [REM_W-1:0]  remaining_ms;
  logic                     last_flag;

  timer_req_t    request_queue[$];
  timer_result_t pending_results[$];
  timer_req_t    active_req;
  int unsigned   gap_left = 0;
  int unsigned   requests_built = 0;
  int unsigned   requests_taken = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   stall_cycles = 0;
  bit            no_idle = 1'b0;

  // shadow of the timer table
  logic [TIME_W-1:0] due_at [TABLE_DEPTH];
  logic [ID_W-1:0]   owner_id [TABLE_DEPTH];
  logic [TAG_W-1:0]  cb_tag [TABLE_DEPTH];
  int                table_fill = 0;
  logic [ID_W-1:0]   id_seed = 16'd1;

  sorted_timer_queue_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start_req),
    .busy_o         (busy),
    .mode_i         (mode),
    .now_ms_i       (now_ms),
    .delay_ms_i     (delay_ms),
    .callback_tag_i (callback_tag),
    .target_id_i    (target_id),
    .result_valid_o (res_valid),
    .status_o       (status),
    .timer_ident_o  (timer_ident),
    .expired_tag_o  (expired_tag),
    .remaining_ms_o (remaining_ms),
    .last_o         (last_flag)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic queue_request(input logic [MODE_W-1:0] op, input logic [TIME_W-1:0] now,
                               input logic [DELAY_W-1:0] delay, input logic [TAG_W-1:0] tag,
                               input logic [ID_W-1:0] target, input bit drain);
    timer_req_t req;
    req.op = op;
    req.now = now;
    req.delay = delay;
    req.tag = tag;
    req.target = target;
    req.gap = draw_gap();
    req.drain = drain;
    request_queue.push_back(req);
    requests_built++;
  endtask

  // Updates the shadow table for one request and queues the results it must produce.
  function automatic void predict_timer_results(input timer_req_t req);
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] diff;
    int            i;
    int            pos;
    int            keep;
    int            due_total;
    int            emitted;
    bit            found;
    timer_result_t r;
    r.sts = STS_OK;
    r.ident = '0;
    r.tag = '0;
    r.remain = '0;
    r.last = 1'b1;
    case (req.op)
      MODE_ADD: begin
        if (table_fill >= TABLE_DEPTH) begin
          r.sts = STS_FULL;
        end else begin
          deadline = req.now + TIME_W'(req.delay);
          id_seed = id_seed + 1'b1;
          pos = table_fill;
          found = 1'b0;
          // goes after every entry whose deadline is not later (wrap-safe)
          for (i = 0; i < table_fill; i++) begin
            diff = deadline - due_at[i];
            if (!found && diff[TIME_W-1]) begin
              pos = i;
              found = 1'b1;
            end
          end
          for (i = table_fill; i > pos; i--) begin
            due_at[i] = due_at[i-1];
            owner_id[i] = owner_id[i-1];
            cb_tag[i] = cb_tag[i-1];
          end
          due_at[pos] = deadline;
          owner_id[pos] = id_seed;
          cb_tag[pos] = req.tag;
          table_fill++;
          r.ident = id_seed;
        end
      end
      MODE_CANCEL: begin
        r.sts = STS_BAD_ID;
        found = 1'b0;
        pos = 0;
        if (req.target != '0) begin
          for (i = 0; i < table_fill; i++) begin
            if (!found && owner_id[i] == req.target) begin
              pos = i;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          for (i = pos; i + 1 < table_fill; i++) begin
            due_at[i] = due_at[i+1];
            owner_id[i] = owner_id[i+1];
            cb_tag[i] = cb_tag[i+1];
          end
          table_fill--;
          r.sts = STS_OK;
        end
      end
      MODE_EXPIRE: begin
        due_total = 0;
        for (i = 0; i < table_fill; i++) begin
          diff = due_at[i] - req.now;
          if (diff == '0 || diff[TIME_W-1]) due_total++;
        end
        if (due_total > RESULT_CAP) due_total = RESULT_CAP;
        if (due_total == 0) begin
          r.sts = STS_NOT_DUE;
        end else begin
          emitted = 0;
          keep = 0;
          for (i = 0; i < table_fill; i++) begin
            diff = due_at[i] - req.now;
            if ((diff == '0 || diff[TIME_W-1]) && emitted < due_total) begin
              r.ident = owner_id[i];
              r.tag = cb_tag[i];
              r.last = (emitted == due_total - 1);
              pending_results.push_back(r);
              emitted++;
            end else begin
              due_at[keep] = due_at[i];
              owner_id[keep] = owner_id[i];
              cb_tag[keep] = cb_tag[i];
              keep++;
            end
          end
          table_fill = keep;
          return;
        end
      end
      MODE_QUERY: begin
        if (table_fill == 0) begin
          r.remain = '1;
        end else begin
          diff = due_at[0] - req.now;
          if (diff[TIME_W-1]) r.remain = '0;
          else if (diff > TIME_W'(REMAIN_MAX)) r.remain = REM_W'(REMAIN_MAX);
          else r.remain = diff[REM_W-1:0];
        end
      end
      MODE_CLR_ALL: begin
        table_fill = 0;
        id_seed = 16'd1;
      end
      default: r.sts = STS_BAD_ID;
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) $display("%0t: mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // request driver: one request per start/busy handshake
  always @(posedge clk) begin : drive_requests
    bit          go;
    int unsigned hold;
    if (rst_n) begin
      go = start_req;
      hold = gap_left;
      if (start_req && !busy) begin
        predict_timer_results(active_req);
        requests_taken++;
        go = 1'b0;
        if (request_queue.size() != 0) hold = request_queue[0].gap;
      end
      if (!go) begin
        if (hold != 0) begin
          hold--;
        end else if (request_queue.size() != 0 &&
                     (!request_queue[0].drain || pending_results.size() == 0)) begin
          active_req = request_queue.pop_front();
          mode <= active_req.op;
          now_ms <= active_req.now;
          delay_ms <= active_req.delay;
          callback_tag <= active_req.tag;
          target_id <= active_req.target;
          go = 1'b1;
        end
      end
      start_req <= go;
      gap_left <= hold;
    end
  end

  // result monitor: results cannot be held off, so every strobe is taken
  always @(posedge clk) begin : check_results
    timer_result_t want;
    if (rst_n && res_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d id %0h", status, timer_ident));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(status), 32'(want.sts));
        check_field("timer_ident", 32'(timer_ident), 32'(want.ident));
        check_field("expired_tag", 32'(expired_tag), 32'(want.tag));
        check_field("remaining_ms", 32'(remaining_ms), 32'(want.remain));
        check_field("last", 32'(last_flag), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start_req && !busy) || res_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0]  base;
    logic [TIME_W-1:0]  clock_ms;
    logic [TIME_W-1:0]  stamp;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    target;
    logic [ID_W-1:0]    gen_id;
    logic [ID_W-1:0]    issued[$];
    int                 n;
    int                 pick;
    bit                 drain;

    base = 32'hFFFF_FF00;
    // empty table, bad ids, reserved modes
    queue_request(MODE_QUERY, base, '0, '0, '0, 1'b0);
    queue_request(MODE_EXPIRE, base, '0, '0, '0, 1'b0);
    queue_request(MODE_CANCEL, base, '0, '0, '0, 1'b0);
    queue_request(MODE_CANCEL, base, '0, '0, '1, 1'b0);
    queue_request(MODE_RSVD_LO, base, '0, '0, '0, 1'b0);
    queue_request(MODE_RSVD_HI, '1, '1, '1, '1, 1'b0);
    // fill the table: zero and max delay, equal deadlines, deadlines across the wrap
    for (n = 0; n < TABLE_DEPTH; n++) begin
      if (n == 0) queue_request(MODE_ADD, base, '0, '1, '0, 1'b0);
      else if (n == 1) queue_request(MODE_ADD, base, '1, '0, '0, 1'b0);
      else if (n % 2 == 0) queue_request(MODE_ADD, base, '0, 8'($urandom), '0, 1'b0);
      else queue_request(MODE_ADD, base, 24'($urandom), 8'($urandom), '0, 1'b0);
    end
    queue_request(MODE_ADD, base, 24'd5, 8'h5A, '0, 1'b0);                // table full
    queue_request(MODE_QUERY, base - 32'h0200_0000, '0, '0, '0, 1'b0);  // saturates
    queue_request(MODE_CANCEL, base, '0, '0, 16'd4, 1'b0);              // mid-table removal
    queue_request(MODE_ADD, base, 24'd1, 8'hC3, '0, 1'b0);
    queue_request(MODE_EXPIRE, base + 32'h00FF_FFFF, '0, '0, '0, 1'b0); // all sixteen due
    queue_request(MODE_CLR_ALL, base, '0, '0, '0, 1'b1);

    queue_request(MODE_ADD, base, '0, '0, '0, 1'b0);
    queue_request(MODE_CANCEL, base, '0, '0, 16'd1, 1'b0);

    // random traffic; time starts just short of the wrap point
    gen_id = 16'd1;
    clock_ms = 32'hFFFF_FC00;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      clock_ms = clock_ms + $urandom_range(0, 60);
      stamp = ($urandom_range(0, 19) == 0) ? 32'($urandom) : clock_ms;
      drain = (n == 0) || ($urandom_range(0, 29) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 9))
          0:       delay = 24'($urandom);
          1, 2, 3: delay = 24'($urandom_range(0, 5000));
          default: delay = 24'($urandom_range(0, 300));
        endcase
        gen_id = gen_id + 1'b1;
        issued.push_back(gen_id);
        queue_request(MODE_ADD, stamp, delay, 8'($urandom), 16'($urandom), drain);
      end else if (pick < 60) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) target = '0;
        else if (pick < 3 || issued.size() == 0) target = 16'($urandom);
        else target = issued[$urandom_range(0, issued.size() - 1)];
        queue_request(MODE_CANCEL, stamp, 24'($urandom), 8'($urandom), target, drain);
      end else if (pick < 78) begin
        queue_request(MODE_EXPIRE, stamp, 24'($urandom), 8'($urandom), 16'($urandom), drain);
      end else if (pick < 90) begin
        queue_request(MODE_QUERY, stamp, 24'($urandom), 8'($urandom), 16'($urandom), drain);
      end else if (pick < 93) begin
        gen_id = 16'd1;
        issued.delete();
        queue_request(MODE_CLR_ALL, stamp, 24'($urandom), 8'($urandom), 16'($urandom), drain);
      end else begin
        queue_request(3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), stamp, 24'($urandom),
                      8'($urandom), 16'($urandom), drain);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (requests_taken != requests_built) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/stq_pkg.sv
src/stq_ctrl.sv
src/stq_datapath.sv
src/sorted_timer_queue_unit.sv
sim/testbench.sv
